// File: rtl/core/ttd_pkg.sv
// Shared constants for the touch-to-display coordinate map.
package ttd_pkg;

    // Raw touch sample and calibration point width
    localparam int COORD_W = 12;

    // Display size defaults
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // Output field widths
    localparam int SCREEN_X_W = 9;
    localparam int SCREEN_Y_W = 8;

    // Configuration port
    localparam int NUM_REGS = 8;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // Register indexes
    localparam logic [2:0] REG_TOP_LEFT_X     = 3'd0;
    localparam logic [2:0] REG_TOP_LEFT_Y     = 3'd1;
    localparam logic [2:0] REG_TOP_RIGHT_X    = 3'd2;
    localparam logic [2:0] REG_TOP_RIGHT_Y    = 3'd3;
    localparam logic [2:0] REG_BOTTOM_LEFT_X  = 3'd4;
    localparam logic [2:0] REG_BOTTOM_LEFT_Y  = 3'd5;
    localparam logic [2:0] REG_BOTTOM_RIGHT_X = 3'd6;
    localparam logic [2:0] REG_BOTTOM_RIGHT_Y = 3'd7;

    // Register reset values
    localparam logic [COORD_W-1:0] COORD_LOW  = 12'd0;
    localparam logic [COORD_W-1:0] COORD_HIGH = 12'd4095;

endpackage

// File: rtl/core/ttd_front.sv
// Front stage: clamp the touch offsets and scale them by the display size.
module ttd_front #(
    parameter int SCREEN_WIDTH  = ttd_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ttd_pkg::SCREEN_HEIGHT_DEF,
    parameter int QW            = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ttd_pkg::COORD_W-1:0] touch_x,
    input  logic [ttd_pkg::COORD_W-1:0] touch_y,
    input  logic [ttd_pkg::COORD_W-1:0] min_x,
    input  logic [ttd_pkg::COORD_W-1:0] range_x,
    input  logic [ttd_pkg::COORD_W-1:0] min_y,
    input  logic [ttd_pkg::COORD_W-1:0] range_y,
    input  logic                        cal_bad,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ttd_pkg::COORD_W-1:0] rem_x,
    output logic [QW-1:0]               acc_x,
    output logic [ttd_pkg::COORD_W-1:0] rem_y,
    output logic [QW-1:0]               acc_y,
    output logic                        inv
);

    localparam int NW = QW + ttd_pkg::COORD_W;
    localparam logic [QW-1:0] W_Q = QW'(SCREEN_WIDTH);
    localparam logic [QW-1:0] H_Q = QW'(SCREEN_HEIGHT);

    logic [ttd_pkg::COORD_W-1:0] dx_raw, dy_raw, dx, dy;
    logic [NW-1:0]               num_x, num_y;
    logic                        valid_reg, valid_next;
    logic [NW-1:0]               num_x_reg, num_y_reg;
    logic                        inv_reg;

    // Clamp offsets to 0..range
    always_comb
    begin
        dx_raw = touch_x - min_x;
        dy_raw = touch_y - min_y;
        if (touch_x <= min_x)
            dx = '0;
        else if (dx_raw > range_x)
            dx = range_x;
        else
            dx = dx_raw;
        if (touch_y <= min_y)
            dy = '0;
        else if (dy_raw > range_y)
            dy = range_y;
        else
            dy = dy_raw;
    end

    // Scale by display size; y is inverted
    assign num_x = NW'(W_Q) * NW'(dx);
    assign num_y = NW'(H_Q) * NW'(range_y - dy);

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Hold stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture products on request acceptance
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            num_x_reg <= num_x;
            num_y_reg <= num_y;
            inv_reg   <= cal_bad;
        end
    end

    assign out_valid = valid_reg;
    assign rem_x     = num_x_reg[NW-1:QW];
    assign acc_x     = num_x_reg[QW-1:0];
    assign rem_y     = num_y_reg[NW-1:QW];
    assign acc_y     = num_y_reg[QW-1:0];
    assign inv       = inv_reg;

endmodule

// File: rtl/core/ttd_div_cell.sv
// One restoring-division step for both axes, with its pipeline register.
module ttd_div_cell #(
    parameter int QW = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ttd_pkg::COORD_W-1:0] divisor_x,
    input  logic [ttd_pkg::COORD_W-1:0] divisor_y,
    input  logic [ttd_pkg::COORD_W-1:0] rem_x_in,
    input  logic [QW-1:0]               acc_x_in,
    input  logic [ttd_pkg::COORD_W-1:0] rem_y_in,
    input  logic [QW-1:0]               acc_y_in,
    input  logic                        inv_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ttd_pkg::COORD_W-1:0] rem_x_out,
    output logic [QW-1:0]               acc_x_out,
    output logic [ttd_pkg::COORD_W-1:0] rem_y_out,
    output logic [QW-1:0]               acc_y_out,
    output logic                        inv_out
);

    localparam int CW = ttd_pkg::COORD_W;

    logic [CW:0]   part_x, part_y, diff_x, diff_y;
    logic          ge_x, ge_y;
    logic [QW:0]   shift_x, shift_y;
    logic [CW-1:0] rem_x_next, rem_y_next;
    logic          valid_reg, valid_next;
    logic [CW-1:0] rem_x_reg, rem_y_reg;
    logic [QW-1:0] acc_x_reg, acc_y_reg;
    logic          inv_reg;

    // Shift in the next numerator bit and trial-subtract the divisor
    always_comb
    begin
        part_x  = {rem_x_in, acc_x_in[QW-1]};
        part_y  = {rem_y_in, acc_y_in[QW-1]};
        diff_x  = part_x - {1'b0, divisor_x};
        diff_y  = part_y - {1'b0, divisor_y};
        ge_x    = part_x >= {1'b0, divisor_x};
        ge_y    = part_y >= {1'b0, divisor_y};
        rem_x_next = ge_x ? diff_x[CW-1:0] : part_x[CW-1:0];
        rem_y_next = ge_y ? diff_y[CW-1:0] : part_y[CW-1:0];
        shift_x = {acc_x_in, ge_x};
        shift_y = {acc_y_in, ge_y};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Hold stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Advance the partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            acc_x_reg <= shift_x[QW-1:0];
            acc_y_reg <= shift_y[QW-1:0];
            inv_reg   <= inv_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign acc_x_out = acc_x_reg;
    assign acc_y_out = acc_y_reg;
    assign inv_out   = inv_reg;

endmodule

// File: rtl/core/touch_to_display_coordinate_map.sv
// Top level: calibration registers, scaling stage and chain of divider cells.
//
// Maps a raw 12-bit touch sample (touch_x, touch_y) to display coordinates
// using four calibration corners written over the APB port (byte address
// 4*i for register i). Registers should only change while the block is idle.
// Input and output are valid/ready channels; one result per request.
// Each accepted request passes the scaling stage and then one
// restoring-division cell per quotient bit, where Q is the quotient width
// clog2(max(SCREEN_WIDTH, SCREEN_HEIGHT) + 1). Throughput: one request
// per cycle while the receiver holds out_ready high.
// Each stage holds its data when the next one is full and stalled, so
// requests keep entering while bubbles remain; a stalled receiver fills the
// chain and then drops in_ready.
// When a calibration range is not positive, calibration_invalid is set and
// both coordinates read zero.
// Reset clears all pipeline valids and loads the default corner points.
module touch_to_display_coordinate_map #(
    parameter int SCREEN_WIDTH  = ttd_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ttd_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttd_pkg::PADDR_W-1:0]   paddr,
    input  logic [ttd_pkg::PDATA_W-1:0]   pwdata,
    output logic [ttd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ttd_pkg::COORD_W-1:0]   touch_x,
    input  logic [ttd_pkg::COORD_W-1:0]   touch_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ttd_pkg::SCREEN_X_W-1:0] screen_x,
    output logic [ttd_pkg::SCREEN_Y_W-1:0] screen_y,
    output logic                          calibration_invalid
);

    localparam int CW        = ttd_pkg::COORD_W;
    localparam int SCALE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int QW        = $clog2(SCALE_MAX + 1);
    localparam int XW        = ttd_pkg::SCREEN_X_W;
    localparam int YW        = ttd_pkg::SCREEN_Y_W;

    logic [CW-1:0] tl_x_reg, tl_y_reg, tr_x_reg, tr_y_reg;
    logic [CW-1:0] bl_x_reg, bl_y_reg, br_x_reg, br_y_reg;
    logic [CW-1:0] min_x, max_x, min_y, max_y, range_x, range_y;
    logic          cal_bad;
    logic          wr_en;
    logic [2:0]    reg_idx;
    logic [CW-1:0] rd_val;

    // Chain links: index 0 is the scaling stage, index QW the last cell
    logic          link_valid [QW+1];
    logic          link_ready [QW+1];
    logic [CW-1:0] link_rem_x [QW+1];
    logic [CW-1:0] link_rem_y [QW+1];
    logic [QW-1:0] link_acc_x [QW+1];
    logic [QW-1:0] link_acc_y [QW+1];
    logic          link_inv   [QW+1];

    logic [QW+XW-1:0] quo_x_ext;
    logic [QW+YW-1:0] quo_y_ext;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // Calibration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_x_reg <= ttd_pkg::COORD_LOW;
            tl_y_reg <= ttd_pkg::COORD_HIGH;
            tr_x_reg <= ttd_pkg::COORD_HIGH;
            tr_y_reg <= ttd_pkg::COORD_HIGH;
            bl_x_reg <= ttd_pkg::COORD_LOW;
            bl_y_reg <= ttd_pkg::COORD_LOW;
            br_x_reg <= ttd_pkg::COORD_HIGH;
            br_y_reg <= ttd_pkg::COORD_LOW;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ttd_pkg::REG_TOP_LEFT_X:     tl_x_reg <= pwdata[CW-1:0];
                ttd_pkg::REG_TOP_LEFT_Y:     tl_y_reg <= pwdata[CW-1:0];
                ttd_pkg::REG_TOP_RIGHT_X:    tr_x_reg <= pwdata[CW-1:0];
                ttd_pkg::REG_TOP_RIGHT_Y:    tr_y_reg <= pwdata[CW-1:0];
                ttd_pkg::REG_BOTTOM_LEFT_X:  bl_x_reg <= pwdata[CW-1:0];
                ttd_pkg::REG_BOTTOM_LEFT_Y:  bl_y_reg <= pwdata[CW-1:0];
                ttd_pkg::REG_BOTTOM_RIGHT_X: br_x_reg <= pwdata[CW-1:0];
                ttd_pkg::REG_BOTTOM_RIGHT_Y: br_y_reg <= pwdata[CW-1:0];
                default:                     tl_x_reg <= tl_x_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx)
            ttd_pkg::REG_TOP_LEFT_X:     rd_val = tl_x_reg;
            ttd_pkg::REG_TOP_LEFT_Y:     rd_val = tl_y_reg;
            ttd_pkg::REG_TOP_RIGHT_X:    rd_val = tr_x_reg;
            ttd_pkg::REG_TOP_RIGHT_Y:    rd_val = tr_y_reg;
            ttd_pkg::REG_BOTTOM_LEFT_X:  rd_val = bl_x_reg;
            ttd_pkg::REG_BOTTOM_LEFT_Y:  rd_val = bl_y_reg;
            ttd_pkg::REG_BOTTOM_RIGHT_X: rd_val = br_x_reg;
            ttd_pkg::REG_BOTTOM_RIGHT_Y: rd_val = br_y_reg;
            default:                     rd_val = '0;
        endcase
    end

    assign prdata = {{(ttd_pkg::PDATA_W - CW){1'b0}}, rd_val};

    // Form the calibrated box and its ranges
    always_comb
    begin
        min_x   = (tl_x_reg < bl_x_reg) ? tl_x_reg : bl_x_reg;
        max_x   = (tr_x_reg > br_x_reg) ? tr_x_reg : br_x_reg;
        min_y   = (bl_y_reg < br_y_reg) ? bl_y_reg : br_y_reg;
        max_y   = (tl_y_reg > tr_y_reg) ? tl_y_reg : tr_y_reg;
        range_x = max_x - min_x;
        range_y = max_y - min_y;
        cal_bad = (max_x <= min_x) || (max_y <= min_y);
    end

    ttd_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .QW            (QW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .touch_x   (touch_x),
        .touch_y   (touch_y),
        .min_x     (min_x),
        .range_x   (range_x),
        .min_y     (min_y),
        .range_y   (range_y),
        .cal_bad   (cal_bad),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .rem_x     (link_rem_x[0]),
        .acc_x     (link_acc_x[0]),
        .rem_y     (link_rem_y[0]),
        .acc_y     (link_acc_y[0]),
        .inv       (link_inv[0])
    );

    // One division cell per quotient bit
    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        ttd_div_cell #(
            .QW (QW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .divisor_x (range_x),
            .divisor_y (range_y),
            .rem_x_in  (link_rem_x[i]),
            .acc_x_in  (link_acc_x[i]),
            .rem_y_in  (link_rem_y[i]),
            .acc_y_in  (link_acc_y[i]),
            .inv_in    (link_inv[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .rem_x_out (link_rem_x[i+1]),
            .acc_x_out (link_acc_x[i+1]),
            .rem_y_out (link_rem_y[i+1]),
            .acc_y_out (link_acc_y[i+1]),
            .inv_out   (link_inv[i+1])
        );
    end

    // Drive the result from the last cell; zero the coordinates when invalid
    assign link_ready[QW] = out_ready;
    assign out_valid      = link_valid[QW];
    assign quo_x_ext      = {{XW{1'b0}}, link_acc_x[QW]};
    assign quo_y_ext      = {{YW{1'b0}}, link_acc_y[QW]};
    assign screen_x       = link_inv[QW] ? '0 : quo_x_ext[XW-1:0];
    assign screen_y       = link_inv[QW] ? '0 : quo_y_ext[YW-1:0];
    assign calibration_invalid = link_inv[QW];

endmodule
